// ===== hw/rtl/vbfs_pkg.sv =====
// Shared types and constants for the virtual bitmap block, including the log2 unit's request and response types.
package vbfs_pkg;
  localparam int BITMAP_BITS = 524288;
  localparam int VIRTUAL_BITS = 512;
  localparam int MAP_AW = $clog2(BITMAP_BITS);
  localparam int SLOT_AW = $clog2(VIRTUAL_BITS);
  localparam int ZC_W = MAP_AW + 1;
  localparam int CLR_LEN = BITMAP_BITS / 32;
  localparam int CLR_AW = $clog2(CLR_LEN);
  localparam logic [33:0] LN2_Q32 = 34'd2977044472;
  localparam logic signed [13:0] EST_MAX = 14'sd8191;
  localparam logic signed [13:0] EST_MIN = -14'sd8192;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_RECORD = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_REC, ST_QRD, ST_QACC, ST_LOG, ST_LOGW, ST_MUL1, ST_MUL2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [19:0] x;
  } log_req_t;

  typedef struct packed {
    logic               done;
    logic signed [22:0] q16;
  } log_rsp_t;
endpackage

// ===== hw/rtl/vbfs_log2.sv =====
// Iterative log2 unit in Q16: one squaring per cycle.
module vbfs_log2 import vbfs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  log_req_t req,
  output log_rsp_t rsp
);
  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [4:0]  k;
  logic [30:0] y;
  logic [15:0] frac;
  logic [61:0] sq;
  logic [31:0] ysq;
  logic [4:0]  k_next;

  always_comb begin
    k_next = 5'd0;
    for (int i = 1; i < 20; i++) begin
      if (req.x[i]) k_next = 5'(i);
    end
  end

  assign sq = 62'(y) * 62'(y);
  assign ysq = sq[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 5'd0;
        k <= k_next;
        y <= 31'({11'd0, req.x} << (5'd30 - k_next));
        frac <= 16'd0;
      end else if (busy) begin
        if (ysq[31]) begin
          y <= ysq[31:1];
          frac <= {frac[14:0], 1'b1};
        end else begin
          y <= ysq[30:0];
          frac <= {frac[14:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q16 = $signed({2'b00, k, (cnt == 5'd16) ? frac : frac});
endmodule

// ===== hw/rtl/virtual_bitmap_flow_size.sv =====
// Virtual bitmap flow size estimator: top level with sequencer and memories.
// After reset the bitmap is cleared 32 bits a cycle, all BITMAP_BITS/32 = 16384 words,
// before the first request is accepted. A record reads the slot word, then the
// bitmap word, and writes it back. A query reads one slot word and one bitmap word
// per active slot, then runs the shared log2 unit four times and two multiply steps;
// a query that finds no zero bits in its slots or in the map skips the logarithms.
// The block is not ready while a request is in progress or its result waits.
module virtual_bitmap_flow_size import vbfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // flow_id, slot, slot_value, zero fill
  input  logic [1:0]  s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // estimate, saturated, zeros_in_map, zero fill
  output logic [1:0]  m_tuser
);
  logic [9:0] virtual_size;
  state_t state, state_next;
  logic [31:0] slot_mem [VIRTUAL_BITS];
  logic [31:0] map_mem [BITMAP_BITS/32];
  logic [31:0] sw_q, mw_q;
  logic [CLR_AW-1:0] clr;
  logic [1:0] act;
  logic [31:0] flow;
  logic [SLOT_AW-1:0] slot;
  logic slot_ok;
  logic [ZC_W-1:0] zc;
  logic [9:0] s_eff, j, zs;
  logic [9:0] zs_next;
  logic [MAP_AW-1:0] bidx;
  logic [1:0] lsel;
  logic signed [24:0] dacc;
  logic signed [59:0] prod;
  logic signed [35:0] lval;
  logic signed [51:0] eprod;
  logic signed [13:0] est;
  logic sat;
  logic ovalid;
  log_req_t lreq;
  log_rsp_t lrsp;

  assign s_tready = (state == ST_IDLE) && !ovalid;
  assign m_tvalid = ovalid;
  assign m_tuser = 2'd0;
  assign m_tdata = {5'd0, zc[19:0], sat, est};
  assign s_eff = (virtual_size == 10'd0) ? 10'd1 :
                 (virtual_size > 10'(VIRTUAL_BITS)) ? 10'(VIRTUAL_BITS) : virtual_size;
  assign bidx = MAP_AW'(flow ^ sw_q);
  assign zs_next = zs + {9'd0, ~mw_q[bidx[4:0]]};
  assign prod = $signed({1'b0, 25'(dacc[24] ? -dacc : dacc)}) * $signed({1'b0, LN2_Q32});
  assign eprod = $signed(lval[24] ? -lval[24:0] : lval[24:0]) * $signed({1'b0, s_eff});

  vbfs_log2 u_log (.clk(clk), .rst(rst), .req(lreq), .rsp(lrsp));

  always_comb begin
    lreq.start = (state == ST_LOG);
    case (lsel)
      2'd0: lreq.x = zc[19:0];
      2'd1: lreq.x = 20'(BITMAP_BITS);
      2'd2: lreq.x = {10'd0, zs};
      default: lreq.x = {10'd0, s_eff};
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == CLR_AW'(CLR_LEN - 1)) state_next = ST_IDLE;
      ST_IDLE: if (s_tvalid && s_tready) state_next = ST_RD;
      ST_RD: begin
        if (act == ACT_RECORD && slot_ok) state_next = ST_QRD;
        else if (act == ACT_QUERY) state_next = ST_QRD;
        else state_next = ST_OUT;
      end
      ST_QRD: state_next = (act == ACT_RECORD) ? ST_REC : ST_QACC;
      ST_REC: state_next = ST_OUT;
      ST_QACC: begin
        if (j != s_eff) state_next = ST_QRD;
        else if (zs_next == 10'd0 || zc == '0) state_next = ST_OUT;
        else state_next = ST_LOG;
      end
      ST_LOG: state_next = ST_LOGW;
      ST_LOGW: if (lrsp.done) state_next = (lsel == 2'd3) ? ST_MUL1 : ST_LOG;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) map_mem[clr] <= 32'd0;
    else if (state == ST_REC) map_mem[bidx[MAP_AW-1:5]] <= mw_q | (32'd1 << bidx[4:0]);
    if (state == ST_IDLE && s_tvalid && s_tready && s_tuser == ACT_LOAD)
      slot_mem[s_tdata[40:32]] <= s_tdata[72:41];
    if (state == ST_RD || state == ST_QACC)
      sw_q <= slot_mem[(act == ACT_QUERY) ? j[SLOT_AW-1:0] : slot];
    mw_q <= map_mem[bidx[MAP_AW-1:5]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      virtual_size <= 10'd512;
      zc <= ZC_W'(BITMAP_BITS);
      clr <= '0;
      ovalid <= 1'b0;
    end else begin
      if (cfg_we) virtual_size <= cfg_wdata;
      if (state == ST_CLEAR) clr <= clr + 1'b1;
      if (ovalid && m_tready) ovalid <= 1'b0;
      if (state == ST_OUT) ovalid <= 1'b1;
      if (state == ST_REC && !mw_q[bidx[4:0]] && zc != '0) zc <= zc - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (s_tvalid && s_tready) begin
        act <= s_tuser;
        flow <= s_tdata[31:0];
        slot <= s_tdata[40:32];
        slot_ok <= 1'b1;
        est <= 14'sd0;
        sat <= 1'b0;
        j <= 10'd0;
        zs <= 10'd0;
        lsel <= 2'd0;
        dacc <= '0;
      end
      ST_RD: if (act == ACT_QUERY) j <= j + 10'd1;
      ST_QACC: begin
        if (j != s_eff) j <= j + 10'd1;
        zs <= zs_next;
        if (j == s_eff) begin
          if (zs_next == 10'd0) begin
            est <= EST_MAX; sat <= 1'b1;
          end else if (zc == '0) begin
            est <= EST_MIN; sat <= 1'b1;
          end
        end
      end
      ST_LOGW: if (lrsp.done) begin
        lsel <= lsel + 2'd1;
        if (lsel == 2'd0 || lsel == 2'd3) dacc <= dacc + 25'(lrsp.q16);
        else dacc <= dacc - 25'(lrsp.q16);
      end
      ST_MUL1: begin
        lval <= dacc[24] ? -36'(prod[59:32]) : 36'(prod[59:32]);
      end
      ST_MUL2: begin
        if (lval[24]) begin
          if ((eprod >>> 16) > 52'sd8192) begin est <= EST_MIN; sat <= 1'b1; end
          else est <= -14'(eprod >>> 16);
        end else begin
          if ((eprod >>> 16) > 52'sd8191) begin est <= EST_MAX; sat <= 1'b1; end
          else est <= 14'(eprod >>> 16);
        end
      end
      default: ;
    endcase
  end

  property p_busy_not_ready;
    @(posedge clk) disable iff (rst) (state != ST_IDLE) |-> !s_tready;
  endproperty
  a_busy: assert property (p_busy_not_ready) else $error("ready while busy");

  property p_zc_down;
    @(posedge clk) disable iff (rst) (state != ST_REC) |=> $stable(zc) || $past(rst);
  endproperty
  a_zc: assert property (p_zc_down) else $error("zero count moved outside record");

  property p_out_hold;
    @(posedge clk) disable iff (rst) (m_tvalid && !m_tready) |=> m_tvalid;
  endproperty
  a_out: assert property (p_out_hold) else $error("result dropped");
endmodule

// ===== tb/virtual_bitmap_flow_size_test.sv =====
// Self-checking testbench for the virtual bitmap flow size estimator.
module virtual_bitmap_flow_size_test;
  import vbfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  typedef struct {
    logic signed [13:0] estimate;
    logic               saturated;
    logic [19:0]        zeros;
  } flow_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  bit          map_bits [BITMAP_BITS];
  logic [31:0] slot_word [VIRTUAL_BITS];
  bit          slot_loaded [VIRTUAL_BITS];
  int unsigned loaded_prefix = 0;
  int unsigned loaded_slots [$];
  int unsigned map_zeros = BITMAP_BITS;
  logic [9:0]  active_size = 10'd512;
  flow_result_t pending_results [$];
  bit          quiet = 1'b0;
  int          errors = 0;
  int          idle_cycles = 0;

  virtual_bitmap_flow_size i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clamped_size();
    if (active_size == 0) return 1;
    if (active_size > VIRTUAL_BITS) return VIRTUAL_BITS;
    return active_size;
  endfunction

  function automatic longint log2_fixed(int unsigned x);
    int unsigned k;
    longint unsigned y;
    longint frac;
    k = 0;
    frac = 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    y = (k <= 30) ? (longint'(x) << (30 - k)) : (longint'(x) >> (k - 30));
    for (int b = 0; b < 16; b++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd2 << 30)) begin
        frac = frac | 1;
        y = y >> 1;
      end
    end
    return (longint'(k) << 16) + frac;
  endfunction

  function automatic longint scale_trunc(longint a, longint unsigned num, int sh);
    longint unsigned mag;
    longint unsigned r;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    r = (mag * num) >> sh;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic flow_result_t predict_result(logic [1:0] act, logic [31:0] flow,
                                                  logic [8:0] slot, logic [31:0] val);
    flow_result_t r;
    int unsigned s;
    int unsigned zs;
    int unsigned idx;
    longint d;
    longint est;
    r.estimate = '0;
    r.saturated = 1'b0;
    if (act == ACT_LOAD) begin
      slot_word[slot] = val;
      if (!slot_loaded[slot]) begin
        slot_loaded[slot] = 1'b1;
        loaded_slots.push_back(slot);
        while (loaded_prefix < VIRTUAL_BITS && slot_loaded[loaded_prefix]) loaded_prefix++;
      end
    end else if (act == ACT_RECORD) begin
      idx = (flow ^ slot_word[slot]) % BITMAP_BITS;
      if (!map_bits[idx]) begin
        map_bits[idx] = 1'b1;
        if (map_zeros > 0) map_zeros--;
      end
    end else if (act == ACT_QUERY) begin
      s = clamped_size();
      zs = 0;
      for (int j = 0; j < s; j++)
        if (!map_bits[(flow ^ slot_word[j]) % BITMAP_BITS]) zs++;
      if (zs == 0) begin
        r.estimate = EST_MAX;
        r.saturated = 1'b1;
      end else if (map_zeros == 0) begin
        r.estimate = EST_MIN;
        r.saturated = 1'b1;
      end else begin
        d = log2_fixed(map_zeros) - log2_fixed(BITMAP_BITS) - log2_fixed(zs) + log2_fixed(s);
        est = scale_trunc(scale_trunc(d, 64'd2977044472, 32), s, 16);
        if (est > 8191) begin
          r.estimate = EST_MAX;
          r.saturated = 1'b1;
        end else if (est < -8192) begin
          r.estimate = EST_MIN;
          r.saturated = 1'b1;
        end else begin
          r.estimate = est[13:0];
        end
      end
    end
    r.zeros = map_zeros[19:0];
    return r;
  endfunction

  task automatic send_request(logic [1:0] act, logic [31:0] flow, logic [8:0] slot,
                              logic [31:0] val);
    if (!quiet && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {7'b0, val, slot, flow};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_result(act, flow, slot, val));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(logic [9:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_size = v;
  endtask

  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4)
      send_request(ACT_UNKNOWN, $urandom, 9'($urandom), $urandom);
    else if (pick < 25 || loaded_slots.size() == 0)
      send_request(ACT_LOAD, $urandom,
                   9'(($urandom_range(1) && loaded_prefix < VIRTUAL_BITS) ?
                      loaded_prefix : $urandom_range(VIRTUAL_BITS - 1)), $urandom);
    else if (pick < 80 || loaded_prefix < clamped_size())
      send_request(ACT_RECORD, ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom,
                   9'(loaded_slots[$urandom_range(loaded_slots.size() - 1)]), $urandom);
    else
      send_request(ACT_QUERY, ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom,
                   9'($urandom), $urandom);
  endtask

  task automatic test_directed();
    write_size(10'd1);
    send_request(ACT_LOAD, 32'h0, 9'd0, 32'h0);
    send_request(ACT_LOAD, 32'hFFFFFFFF, 9'd0, 32'hFFFFFFFF);
    send_request(ACT_LOAD, 32'h0, 9'd1, 32'h12345678);
    send_request(ACT_LOAD, 32'h0, 9'd511, 32'hA5A5A5A5);
    send_request(ACT_QUERY, 32'h0, 9'd0, 32'h0);
    send_request(ACT_RECORD, 32'h0, 9'd0, 32'h0);
    send_request(ACT_RECORD, 32'h0, 9'd0, 32'hFFFFFFFF);
    send_request(ACT_QUERY, 32'h0, 9'd0, 32'h0);
    send_request(ACT_RECORD, 32'hFFFFFFFF, 9'd511, 32'h0);
    send_request(ACT_RECORD, 32'h5A5A5A5A, 9'd1, 32'h0);
    send_request(ACT_QUERY, 32'h1, 9'd511, 32'hFFFFFFFF);
    send_request(ACT_UNKNOWN, 32'hFFFFFFFF, 9'd511, 32'hFFFFFFFF);
    send_request(ACT_QUERY, 32'hFFFFFFFF, 9'd0, 32'h0);
    write_size(10'd0);
    send_request(ACT_QUERY, 32'h0, 9'd0, 32'h0);
    send_request(ACT_QUERY, 32'h12345678, 9'd0, 32'h0);
    write_size(10'd2);
    send_request(ACT_RECORD, 32'h12345678, 9'd1, 32'h0);
    send_request(ACT_QUERY, 32'h12345678, 9'd0, 32'h0);
  endtask

  task automatic test_random_sizes();
    logic [9:0] sizes [4] = '{10'd2, 10'd37, 10'd255, 10'd1};
    foreach (sizes[i]) begin
      write_size(sizes[i]);
      quiet = (i == 2);
      repeat (130) random_request();
      if (i == 1) begin
        for (int j = 0; j < clamped_size(); j++)
          if (!slot_loaded[j]) send_request(ACT_LOAD, $urandom, 9'(j), $urandom);
        drain();
        send_request(ACT_QUERY, $urandom, 9'($urandom), $urandom);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_full_size();
    logic [9:0] sizes [3] = '{10'd512, 10'd1023, 10'd700};
    for (int j = 0; j < VIRTUAL_BITS; j++)
      if (!slot_loaded[j]) send_request(ACT_LOAD, $urandom, 9'(j), $urandom);
    foreach (sizes[i]) begin
      write_size(sizes[i]);
      repeat (40) random_request();
    end
  endtask

  always @(posedge clk) begin
    flow_result_t want;
    if (!rst) begin
      m_tready <= quiet || ($urandom_range(99) >= 10);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("virtual_bitmap_flow_size: mismatch");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[13:0] !== want.estimate) begin
            $display("%0t: estimate expected %0d got %0d", $time, want.estimate,
                     $signed(m_tdata[13:0]));
            errors++;
          end
          if (m_tdata[14] !== want.saturated) begin
            $display("%0t: saturated expected %0d got %0d", $time, want.saturated,
                     m_tdata[14]);
            errors++;
          end
          if (m_tdata[34:15] !== want.zeros) begin
            $display("%0t: zeros_in_map expected %0d got %0d", $time, want.zeros,
                     m_tdata[34:15]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_sizes();
    test_full_size();
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("virtual_bitmap_flow_size: match");
    else
      $display("virtual_bitmap_flow_size: mismatch");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/vbfs_pkg.sv
hw/rtl/vbfs_log2.sv
hw/rtl/virtual_bitmap_flow_size.sv
tb/virtual_bitmap_flow_size_test.sv
